FILE: rtl/mse_pkg.sv
// ---------------------------------------------------------------------------
// Moebius surface evaluator package
// Shared widths, register indexes, angle constants and the CORDIC arctangent
// table for the surface evaluator and its trigonometry pipeline.
// ---------------------------------------------------------------------------
package mse_pkg;

  localparam int FRAC_BITS_DEF = 16;

  localparam int ACROSS_W  = 18;
  localparam int AROUND_W  = 20;
  localparam int ORDER_W   = 2;
  localparam int COORD_W   = 32;
  localparam int REG_W     = 23;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_RADIUS     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HALF_WIDTH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DERIV_EN   = 2'd2;

  localparam logic [ORDER_W-1:0] ORDER_MAX = 2'd2;

  // Trigonometry works in Q2.30.
  localparam int TRIG_BITS    = 30;
  localparam int TRIG_W       = 32;
  localparam int CORDIC_STEPS = 30;
  localparam int CORDIC_W     = 34;
  localparam int ANGR_W       = 35;

  localparam logic [63:0] CORDIC_GAIN = 64'd652032874;
  localparam logic [63:0] ANG_TWO_PI  = 64'd6746518852;
  localparam logic [63:0] ANG_PI      = 64'd3373259426;
  localparam logic [63:0] ANG_HALF_PI = 64'd1686629713;

  // Number of compare-subtract steps that bring a magnitude of mw bits below 2*pi.
  function automatic int nr_steps(input int mw);
    return ((mw > 33) ? (mw - 33) : 0) + 1;
  endfunction

  // Register stages of the trigonometry pipeline for an angle of aw bits.
  function automatic int trig_latency(input int aw);
    return nr_steps(aw) + 34;
  endfunction

  function automatic logic [31:0] atan_at(input int i);
    logic [31:0] a;
    case (i)
      0:  a = 32'h3243F6A8;
      1:  a = 32'h1DAC6705;
      2:  a = 32'h0FADBAFC;
      3:  a = 32'h07F56EA6;
      4:  a = 32'h03FEAB76;
      5:  a = 32'h01FFD55B;
      6:  a = 32'h00FFFAAA;
      7:  a = 32'h007FFF55;
      8:  a = 32'h003FFFEA;
      9:  a = 32'h001FFFFD;
      10: a = 32'h000FFFFF;
      11: a = 32'h0007FFFF;
      12: a = 32'h0003FFFF;
      13: a = 32'h0001FFFF;
      14: a = 32'h0000FFFF;
      15: a = 32'h00007FFF;
      16: a = 32'h00003FFF;
      17: a = 32'h00001FFF;
      18: a = 32'h00000FFF;
      19: a = 32'h000007FF;
      20: a = 32'h000003FF;
      21: a = 32'h000001FF;
      22: a = 32'h000000FF;
      23: a = 32'h0000007F;
      24: a = 32'h0000003F;
      25: a = 32'h0000001F;
      26: a = 32'h0000000F;
      27: a = 32'h00000008;
      28: a = 32'h00000004;
      29: a = 32'h00000002;
      default: a = 32'h00000000;
    endcase
    return a;
  endfunction

endpackage

FILE: rtl/mse_trig.sv
// ---------------------------------------------------------------------------
// Moebius surface evaluator trigonometry pipeline
// Reduces an angle modulo 2*pi, folds it into [-pi/2, pi/2] and runs a
// fully pipelined rotation-mode CORDIC. mse_pkg::trig_latency counts its register stages.
// ---------------------------------------------------------------------------
module mse_trig #(
  parameter int ANG_W = 34
) (
  input  logic                             clk,
  input  logic                             en,
  input  logic signed [ANG_W-1:0]          ang,
  output logic signed [mse_pkg::TRIG_W-1:0] cos_v,
  output logic signed [mse_pkg::TRIG_W-1:0] sin_v
);

  localparam int NR = mse_pkg::nr_steps(ANG_W);
  localparam int RW = (ANG_W > 34) ? ANG_W : 34;
  localparam int AR = mse_pkg::ANGR_W;
  localparam int CW = mse_pkg::CORDIC_W;
  localparam int NS = mse_pkg::CORDIC_STEPS;

  localparam logic [RW-1:0]        TWO_PI_R = RW'(mse_pkg::ANG_TWO_PI);
  localparam logic signed [AR-1:0] TWO_PI_A = AR'(mse_pkg::ANG_TWO_PI);
  localparam logic signed [AR-1:0] PI_A     = AR'(mse_pkg::ANG_PI);
  localparam logic signed [AR-1:0] HALF_A   = AR'(mse_pkg::ANG_HALF_PI);
  localparam logic signed [CW-1:0] GAIN_C   = CW'(mse_pkg::CORDIC_GAIN);

  logic [ANG_W-1:0] mag_in;
  logic [RW-1:0]    mag [NR+1];
  logic             sgn [NR+1];

  logic signed [AR-1:0] rem_s;
  logic signed [AR-1:0] wrap_next;
  logic signed [AR-1:0] wrap;
  logic signed [AR-1:0] fold_next;
  logic                 neg_next;

  logic signed [CW-1:0] x [NS+1];
  logic signed [CW-1:0] y [NS+1];
  logic signed [AR-1:0] z [NS+1];
  logic                 ng [NS+1];

  assign mag_in = ang[ANG_W-1] ? ANG_W'(-ang) : ANG_W'(ang);

  always_ff @(posedge clk) begin
    if (en) begin
      sgn[0] <= ang[ANG_W-1];
      mag[0] <= RW'(mag_in);
    end
  end

  // Restoring reduction of the magnitude, one power-of-two multiple of 2*pi per stage.
  for (genvar t = 0; t < NR; t++) begin : g_red
    localparam int K = NR - 1 - t;
    localparam logic [RW-1:0] STEP = TWO_PI_R << K;
    always_ff @(posedge clk) begin
      if (en) begin
        sgn[t+1] <= sgn[t];
        mag[t+1] <= (mag[t] >= STEP) ? (mag[t] - STEP) : mag[t];
      end
    end
  end

  // The remainder keeps the sign of the angle and is then wrapped into [-pi, pi].
  always_comb begin
    rem_s = AR'($signed({1'b0, mag[NR][33:0]}));
    if (sgn[NR]) begin
      rem_s = -rem_s;
    end
    wrap_next = rem_s;
    if (rem_s > PI_A) begin
      wrap_next = rem_s - TWO_PI_A;
    end else if (rem_s < -PI_A) begin
      wrap_next = rem_s + TWO_PI_A;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      wrap <= wrap_next;
    end
  end

  // Folding by pi negates both sine and cosine.
  always_comb begin
    fold_next = wrap;
    neg_next  = 1'b0;
    if (wrap > HALF_A) begin
      fold_next = wrap - PI_A;
      neg_next  = 1'b1;
    end else if (wrap < -HALF_A) begin
      fold_next = wrap + PI_A;
      neg_next  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x[0]  <= GAIN_C;
      y[0]  <= '0;
      z[0]  <= fold_next;
      ng[0] <= neg_next;
    end
  end

  for (genvar i = 0; i < NS; i++) begin : g_cordic
    localparam logic signed [AR-1:0] ATAN = AR'(mse_pkg::atan_at(i));
    always_ff @(posedge clk) begin
      if (en) begin
        ng[i+1] <= ng[i];
        if (!z[i][AR-1]) begin
          x[i+1] <= x[i] - (y[i] >>> i);
          y[i+1] <= y[i] + (x[i] >>> i);
          z[i+1] <= z[i] - ATAN;
        end else begin
          x[i+1] <= x[i] + (y[i] >>> i);
          y[i+1] <= y[i] - (x[i] >>> i);
          z[i+1] <= z[i] + ATAN;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cos_v <= mse_pkg::TRIG_W'(ng[NS] ? -x[NS] : x[NS]);
      sin_v <= mse_pkg::TRIG_W'(ng[NS] ? -y[NS] : y[NS]);
    end
  end

endmodule

FILE: rtl/moebius_surface_eval_core.sv
// ---------------------------------------------------------------------------
// Moebius strip surface evaluator
// Evaluates position and partial derivatives of a Moebius strip per input word.
// ---------------------------------------------------------------------------
// Usage: an input word (across, around, order_across, order_around) is taken
// when in_valid is high and in_stall is low. For each word the block emits
// (order_across+1)*(order_around+1) result words in row-major order over
// (u-order, v-order), or a single position word when derivatives_enable is 0;
// an order of 3 counts as 2. last_result marks the final word of each input.
// A result word is taken when out_valid is high and out_stall is low.
// Configuration goes through cfg_valid/cfg_ready (always ready) with
// cfg_index selecting radius, half_width or derivatives_enable; writes to
// other indexes are dropped. Write configuration only while the block is idle.
// An input word passes the entry register, the trigonometry pipeline (angle
// reduction and the 30-step CORDIC), the product and sum stages and the
// result register. Input words are taken every cycle while the pipeline
// flows; the result port sends one word per cycle while out_stall is low,
// and an item has at most 9 results. When the receiver stalls,
// the current result holds and the whole pipeline freezes as soon as a
// finished item waits behind it, raising in_stall. Reset empties the pipeline
// and restores radius 1.0, half_width 1.0 and derivatives enabled.
// ---------------------------------------------------------------------------
module moebius_surface_eval_core #(
  parameter int FRAC_BITS = mse_pkg::FRAC_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [mse_pkg::ACROSS_W-1:0]   across,
  input  logic signed [mse_pkg::AROUND_W-1:0]   around,
  input  logic [mse_pkg::ORDER_W-1:0]           order_across,
  input  logic [mse_pkg::ORDER_W-1:0]           order_around,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [mse_pkg::ORDER_W-1:0]           deriv_across,
  output logic [mse_pkg::ORDER_W-1:0]           deriv_around,
  output logic signed [mse_pkg::COORD_W-1:0]    coord_x,
  output logic signed [mse_pkg::COORD_W-1:0]    coord_y,
  output logic signed [mse_pkg::COORD_W-1:0]    coord_z,
  output logic                                  last_result,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [mse_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [mse_pkg::REG_W-1:0]             cfg_data
);

  localparam int OW  = mse_pkg::ORDER_W;
  localparam int CDW = mse_pkg::COORD_W;
  localparam int TW  = mse_pkg::TRIG_W;
  // Registers are wide enough to hold their reset value of 1.0.
  localparam int RGW = (FRAC_BITS + 1 > mse_pkg::REG_W) ? FRAC_BITS + 1 : mse_pkg::REG_W;
  localparam int PRW = RGW + 1 + mse_pkg::ACROSS_W;
  localparam int QW  = PRW - FRAC_BITS;
  localparam int VW  = ((QW > RGW + 1) ? QW : RGW + 1) + 4;
  localparam int PW  = VW + TW;
  localparam int SW  = (VW + 2 > CDW + 1) ? VW + 2 : CDW + 1;
  localparam int ANG_W = mse_pkg::AROUND_W + mse_pkg::TRIG_BITS - FRAC_BITS;
  localparam int TL  = mse_pkg::trig_latency(ANG_W);
  localparam int NV  = 6;

  localparam logic signed [PRW-1:0] Q_HALF  = PRW'(1) << (FRAC_BITS - 1);
  localparam logic signed [SW-1:0]  SAT_MAX = {{(SW-CDW+1){1'b0}}, {(CDW-1){1'b1}}};
  localparam logic signed [SW-1:0]  SAT_MIN = ~SAT_MAX;

  // Vector slots in the result set: u-order 0 then 1, v-order 0..2 within.
  localparam int V00 = 0;
  localparam int V01 = 1;
  localparam int V02 = 2;
  localparam int V10 = 3;
  localparam int V11 = 4;
  localparam int V12 = 5;

  typedef struct packed {
    logic [OW-1:0] d1;
    logic [OW-1:0] d2;
  } ord_t;

  function automatic logic signed [VW-1:0] rnd(input logic signed [PW-1:0] p, input int s);
    logic signed [PW-1:0] h;
    h = '0;
    h[s-1] = 1'b1;
    return VW'((p + h) >>> s);
  endfunction

  function automatic logic signed [CDW-1:0] sat(input logic signed [SW-1:0] v);
    logic signed [CDW-1:0] r;
    if (v > SAT_MAX) begin
      r = CDW'(SAT_MAX);
    end else if (v < SAT_MIN) begin
      r = CDW'(SAT_MIN);
    end else begin
      r = CDW'(v);
    end
    return r;
  endfunction

  function automatic logic signed [SW-1:0] ext(input logic signed [VW-1:0] v);
    return SW'(v);
  endfunction

  // Configuration registers.
  logic [RGW-1:0] radius;
  logic [RGW-1:0] half_width;
  logic           deriv_en;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      radius     <= RGW'(1) << FRAC_BITS;
      half_width <= RGW'(1) << FRAC_BITS;
      deriv_en   <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        mse_pkg::REG_RADIUS:     radius     <= RGW'(cfg_data);
        mse_pkg::REG_HALF_WIDTH: half_width <= RGW'(cfg_data);
        mse_pkg::REG_DERIV_EN:   deriv_en   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Pipeline control: every stage moves together when adv is high.
  logic adv;
  logic load;
  logic take;
  logic is_last;

  // Entry stage: orders are clamped (or zeroed with derivatives off) and W*u is formed.
  logic                            e_valid;
  logic signed [mse_pkg::AROUND_W-1:0] e_v;
  logic signed [PRW-1:0]           e_prod;
  ord_t                            e_ord;
  logic signed [PRW-1:0]           prod_in;
  ord_t                            ord_in;

  assign prod_in = $signed({1'b0, half_width}) * across;

  always_comb begin
    ord_in.d1 = (order_across > mse_pkg::ORDER_MAX) ? mse_pkg::ORDER_MAX : order_across;
    ord_in.d2 = (order_around > mse_pkg::ORDER_MAX) ? mse_pkg::ORDER_MAX : order_around;
    if (!deriv_en) begin
      ord_in = '0;
    end
  end

  assign in_stall = !adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      e_valid <= 1'b0;
    end else if (adv) begin
      e_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      e_v    <= around;
      e_prod <= prod_in;
      e_ord  <= ord_in;
    end
  end

  // Trigonometry of v and v/2.
  logic signed [ANG_W-1:0] ang1;
  logic signed [ANG_W-1:0] ang2;
  logic signed [TW-1:0]    c1;
  logic signed [TW-1:0]    s1;
  logic signed [TW-1:0]    c2;
  logic signed [TW-1:0]    s2;

  assign ang1 = ANG_W'(e_v) <<< (mse_pkg::TRIG_BITS - FRAC_BITS);
  assign ang2 = ANG_W'(e_v) <<< (mse_pkg::TRIG_BITS - 1 - FRAC_BITS);

  mse_trig #(.ANG_W(ANG_W)) u_trig_full (
    .clk   (clk),
    .en    (adv),
    .ang   (ang1),
    .cos_v (c1),
    .sin_v (s1)
  );

  mse_trig #(.ANG_W(ANG_W)) u_trig_half (
    .clk   (clk),
    .en    (adv),
    .ang   (ang2),
    .cos_v (c2),
    .sin_v (s2)
  );

  // Side delay line that keeps q and the orders in step with the trig units.
  logic                 sd_valid [TL];
  logic signed [QW-1:0] sd_q     [TL];
  ord_t                 sd_ord   [TL];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < TL; k++) begin
        sd_valid[k] <= 1'b0;
      end
    end else if (adv) begin
      sd_valid[0] <= e_valid;
      for (int k = 1; k < TL; k++) begin
        sd_valid[k] <= sd_valid[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sd_q[0]   <= QW'((e_prod + Q_HALF) >>> FRAC_BITS);
      sd_ord[0] <= e_ord;
      for (int k = 1; k < TL; k++) begin
        sd_q[k]   <= sd_q[k-1];
        sd_ord[k] <= sd_ord[k-1];
      end
    end
  end

  // Stage 1: products with the half-angle terms.
  logic                 m1_valid;
  ord_t                 m1_ord;
  logic signed [PW-1:0] m1_pqc, m1_pqs, m1_pwc, m1_pws;
  logic signed [TW-1:0] m1_c1, m1_s1;

  always_ff @(posedge clk) begin
    if (adv) begin
      m1_ord <= sd_ord[TL-1];
      m1_pqc <= VW'(sd_q[TL-1]) * c2;
      m1_pqs <= VW'(sd_q[TL-1]) * s2;
      m1_pwc <= $signed({1'b0, half_width}) * c2;
      m1_pws <= $signed({1'b0, half_width}) * s2;
      m1_c1  <= c1;
      m1_s1  <= s1;
    end
  end

  // Stage 2: rounding, and A = R + q*cos(v/2).
  logic                 m2_valid;
  ord_t                 m2_ord;
  logic signed [VW-1:0] m2_qc, m2_qs, m2_wc, m2_ws, m2_a;
  logic signed [VW-1:0] m2_qc31, m2_qs32, m2_wc31, m2_ws32;
  logic signed [TW-1:0] m2_c1, m2_s1;

  always_ff @(posedge clk) begin
    if (adv) begin
      m2_ord  <= m1_ord;
      m2_qc   <= rnd(m1_pqc, 30);
      m2_qs   <= rnd(m1_pqs, 30);
      m2_wc   <= rnd(m1_pwc, 30);
      m2_ws   <= rnd(m1_pws, 30);
      m2_a    <= $signed(VW'(radius)) + rnd(m1_pqc, 30);
      m2_qc31 <= rnd(m1_pqc, 31);
      m2_qs32 <= rnd(m1_pqs, 32);
      m2_wc31 <= rnd(m1_pwc, 31);
      m2_ws32 <= rnd(m1_pws, 32);
      m2_c1   <= m1_c1;
      m2_s1   <= m1_s1;
    end
  end

  // Stage 3: products with the full-angle terms.
  logic                 m3_valid;
  ord_t                 m3_ord;
  logic signed [PW-1:0] m3_ac, m3_as, m3_qsc, m3_qss, m3_qcc, m3_qcs;
  logic signed [PW-1:0] m3_wcc, m3_wcs, m3_wsc, m3_wss;
  logic signed [VW-1:0] m3_qs, m3_ws, m3_qc31, m3_qs32, m3_wc31, m3_ws32;

  always_ff @(posedge clk) begin
    if (adv) begin
      m3_ord  <= m2_ord;
      m3_ac   <= m2_a * m2_c1;
      m3_as   <= m2_a * m2_s1;
      m3_qsc  <= m2_qs * m2_c1;
      m3_qss  <= m2_qs * m2_s1;
      m3_qcc  <= m2_qc * m2_c1;
      m3_qcs  <= m2_qc * m2_s1;
      m3_wcc  <= m2_wc * m2_c1;
      m3_wcs  <= m2_wc * m2_s1;
      m3_wsc  <= m2_ws * m2_c1;
      m3_wss  <= m2_ws * m2_s1;
      m3_qs   <= m2_qs;
      m3_ws   <= m2_ws;
      m3_qc31 <= m2_qc31;
      m3_qs32 <= m2_qs32;
      m3_wc31 <= m2_wc31;
      m3_ws32 <= m2_ws32;
    end
  end

  // Stage 4: rounding of every product term; a product may be rounded twice
  // when it appears at two different scales.
  logic                 m4_valid;
  ord_t                 m4_ord;
  logic signed [VW-1:0] ac30, as30, qsc31, qss31, qcc32, qcs32, qss30, qsc30;
  logic signed [VW-1:0] wcc30, wcs30, wsc31, wss31, wcc32, wcs32, wss30, wsc30;
  logic signed [VW-1:0] m4_qs, m4_ws, m4_qc31, m4_qs32, m4_wc31, m4_ws32;

  always_ff @(posedge clk) begin
    if (adv) begin
      m4_ord  <= m3_ord;
      ac30    <= rnd(m3_ac, 30);
      as30    <= rnd(m3_as, 30);
      qsc31   <= rnd(m3_qsc, 31);
      qss31   <= rnd(m3_qss, 31);
      qcc32   <= rnd(m3_qcc, 32);
      qcs32   <= rnd(m3_qcs, 32);
      qss30   <= rnd(m3_qss, 30);
      qsc30   <= rnd(m3_qsc, 30);
      wcc30   <= rnd(m3_wcc, 30);
      wcs30   <= rnd(m3_wcs, 30);
      wsc31   <= rnd(m3_wsc, 31);
      wss31   <= rnd(m3_wss, 31);
      wcc32   <= rnd(m3_wcc, 32);
      wcs32   <= rnd(m3_wcs, 32);
      wss30   <= rnd(m3_wss, 30);
      wsc30   <= rnd(m3_wsc, 30);
      m4_qs   <= m3_qs;
      m4_ws   <= m3_ws;
      m4_qc31 <= m3_qc31;
      m4_qs32 <= m3_qs32;
      m4_wc31 <= m3_wc31;
      m4_ws32 <= m3_ws32;
    end
  end

  // Stage 5: sums and saturation into the six result vectors.
  logic                  m5_valid;
  ord_t                  m5_ord;
  logic signed [CDW-1:0] m5_vec [NV][3];

  always_ff @(posedge clk) begin
    if (adv) begin
      m5_ord <= m4_ord;
      m5_vec[V00][0] <= sat(ext(ac30));
      m5_vec[V00][1] <= sat(ext(as30));
      m5_vec[V00][2] <= sat(ext(m4_qs));
      m5_vec[V01][0] <= sat(-ext(qsc31) - ext(as30));
      m5_vec[V01][1] <= sat(-ext(qss31) + ext(ac30));
      m5_vec[V01][2] <= sat(ext(m4_qc31));
      m5_vec[V02][0] <= sat(-ext(qcc32) + ext(qss30) - ext(ac30));
      m5_vec[V02][1] <= sat(-ext(qcs32) - ext(qsc30) - ext(as30));
      m5_vec[V02][2] <= sat(-ext(m4_qs32));
      m5_vec[V10][0] <= sat(ext(wcc30));
      m5_vec[V10][1] <= sat(ext(wcs30));
      m5_vec[V10][2] <= sat(ext(m4_ws));
      m5_vec[V11][0] <= sat(-(ext(wsc31) + ext(wcs30)));
      m5_vec[V11][1] <= sat(-(ext(wss31) - ext(wcc30)));
      m5_vec[V11][2] <= sat(ext(m4_wc31));
      m5_vec[V12][0] <= sat(-(ext(wcc32) - ext(wss30) + ext(wcc30)));
      m5_vec[V12][1] <= sat(-(ext(wcs32) + ext(wsc30) + ext(wcs30)));
      m5_vec[V12][2] <= sat(-ext(m4_ws32));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m1_valid <= 1'b0;
      m2_valid <= 1'b0;
      m3_valid <= 1'b0;
      m4_valid <= 1'b0;
      m5_valid <= 1'b0;
    end else if (adv) begin
      m1_valid <= sd_valid[TL-1];
      m2_valid <= m1_valid;
      m3_valid <= m2_valid;
      m4_valid <= m3_valid;
      m5_valid <= m4_valid;
    end
  end

  // Result sequencer: holds one item's vectors and walks its (u, v) orders.
  logic                  hold_valid;
  ord_t                  hold_ord;
  logic signed [CDW-1:0] hold_vec [NV][3];
  logic [OW-1:0]         ci;
  logic [OW-1:0]         cj;
  logic [2:0]            sel;

  assign is_last = (ci == hold_ord.d1) && (cj == hold_ord.d2);
  assign take    = hold_valid && !out_stall;
  assign load    = !hold_valid || (take && is_last);
  assign adv     = load || !m5_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
      ci         <= '0;
      cj         <= '0;
    end else if (load) begin
      hold_valid <= m5_valid;
      ci         <= '0;
      cj         <= '0;
    end else if (take) begin
      if (cj == hold_ord.d2) begin
        cj <= '0;
        ci <= ci + 1'b1;
      end else begin
        cj <= cj + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      hold_ord <= m5_ord;
      hold_vec <= m5_vec;
    end
  end

  assign sel = 3'(cj) + (ci[0] ? 3'd3 : 3'd0);

  // Every result of u-order two is the zero vector.
  always_comb begin
    if (ci == mse_pkg::ORDER_MAX) begin
      coord_x = '0;
      coord_y = '0;
      coord_z = '0;
    end else begin
      coord_x = hold_vec[sel][0];
      coord_y = hold_vec[sel][1];
      coord_z = hold_vec[sel][2];
    end
  end

  assign out_valid    = hold_valid;
  assign deriv_across = ci;
  assign deriv_around = cj;
  assign last_result  = is_last;

endmodule

FILE: bench/moebius_surface_eval_core_tb.sv
// ---------------------------------------------------------------------------
// Moebius surface evaluator testbench
// Drives parameter words through the evaluator under bursty input and random
// output stall, predicts every position and derivative word in the same fixed
// point arithmetic, and checks each result word against the oldest prediction.
// ---------------------------------------------------------------------------
module moebius_surface_eval_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // One expected result word.
  typedef struct {
    logic [1:0]  du;
    logic [1:0]  dv;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic        last;
  } surf_word_t;

  // Fixed point helpers of the surface predictor.
  function automatic longint asr64(longint v, int s);
    return v >>> s;
  endfunction

  // Product with a trig factor, rounded half up, shifted by s.
  function automatic longint tmul(longint a, longint t, int s);
    return (a * t + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic logic [31:0] sat32(longint v);
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return v[31:0];
  endfunction

  // Rotation-mode CORDIC with reduction into [-pi/2, pi/2].
  function automatic void cordic_sincos(input longint ang, output longint c,
                                        output longint s);
    longint a, x, y, dx, dy;
    longint two_pi, pi, half_pi;
    bit neg;
    two_pi = longint'(mse_pkg::ANG_TWO_PI);
    pi = longint'(mse_pkg::ANG_PI);
    half_pi = longint'(mse_pkg::ANG_HALF_PI);
    a = ang % two_pi;
    x = longint'(mse_pkg::CORDIC_GAIN);
    y = 0;
    neg = 0;
    if (a > pi) a -= two_pi;
    if (a < -pi) a += two_pi;
    if (a > half_pi) begin
      a -= pi;
      neg = 1;
    end else if (a < -half_pi) begin
      a += pi;
      neg = 1;
    end
    for (int i = 0; i < mse_pkg::CORDIC_STEPS; i++) begin
      dx = asr64(y, i);
      dy = asr64(x, i);
      if (a >= 0) begin
        x -= dx;
        y += dy;
        a -= longint'(mse_pkg::atan_at(i));
      end else begin
        x += dx;
        y -= dy;
        a += longint'(mse_pkg::atan_at(i));
      end
    end
    c = neg ? -x : x;
    s = neg ? -y : y;
  endfunction

  // Scoreboard: holds the predicted result words and the register copies.
  class surf_scoreboard;
    surf_word_t pending[$];
    longint radius_q, width_q;
    bit deriv_en;
    int errors;
    int words_checked;

    function new();
      radius_q = 65536;
      width_q = 65536;
      deriv_en = 1;
      errors = 0;
      words_checked = 0;
    endfunction

    function void note_config(logic [1:0] idx, logic [22:0] data);
      if (idx == mse_pkg::REG_RADIUS) radius_q = data;
      else if (idx == mse_pkg::REG_HALF_WIDTH) width_q = data;
      else if (idx == mse_pkg::REG_DERIV_EN) deriv_en = data[0];
    endfunction

    // Predict every result word caused by one accepted parameter word.
    function void note_input(logic signed [17:0] u_in, logic signed [19:0] v_in,
                             logic [1:0] ou, logic [1:0] ov);
      longint u, v, c1, s1, c2, s2, q, qc, qs, av, wc, ws, w, r;
      longint vec[3][3][3];
      int du_max, dv_max;
      surf_word_t wd;
      u = u_in;
      v = v_in;
      w = width_q;
      r = radius_q;
      du_max = (ou > 2) ? 2 : ou;
      dv_max = (ov > 2) ? 2 : ov;
      if (!deriv_en) begin
        du_max = 0;
        dv_max = 0;
      end
      cordic_sincos(v * 16384, c1, s1);
      cordic_sincos(v * 8192, c2, s2);
      q = (w * u + 32768) >>> 16;
      qc = tmul(q, c2, 30);
      qs = tmul(q, s2, 30);
      av = r + qc;
      wc = tmul(w, c2, 30);
      ws = tmul(w, s2, 30);
      foreach (vec[i, j, k]) vec[i][j][k] = 0;
      vec[0][0][0] = tmul(av, c1, 30);
      vec[0][0][1] = tmul(av, s1, 30);
      vec[0][0][2] = qs;
      vec[1][0][0] = tmul(wc, c1, 30);
      vec[1][0][1] = tmul(wc, s1, 30);
      vec[1][0][2] = ws;
      vec[0][1][0] = -tmul(qs, c1, 31) - tmul(av, s1, 30);
      vec[0][1][1] = -tmul(qs, s1, 31) + tmul(av, c1, 30);
      vec[0][1][2] = tmul(q, c2, 31);
      vec[0][2][0] = -tmul(qc, c1, 32) + tmul(qs, s1, 30) - tmul(av, c1, 30);
      vec[0][2][1] = -tmul(qc, s1, 32) - tmul(qs, c1, 30) - tmul(av, s1, 30);
      vec[0][2][2] = -tmul(q, s2, 32);
      vec[1][1][0] = -(tmul(ws, c1, 31) + tmul(wc, s1, 30));
      vec[1][1][1] = -(tmul(ws, s1, 31) - tmul(wc, c1, 30));
      vec[1][1][2] = tmul(w, c2, 31);
      vec[1][2][0] = -(tmul(wc, c1, 32) - tmul(ws, s1, 30) + tmul(wc, c1, 30));
      vec[1][2][1] = -(tmul(wc, s1, 32) + tmul(ws, c1, 30) + tmul(wc, s1, 30));
      vec[1][2][2] = -tmul(w, s2, 32);
      for (int i = 0; i <= du_max; i++) begin
        for (int j = 0; j <= dv_max; j++) begin
          wd.du = 2'(i);
          wd.dv = 2'(j);
          wd.x = sat32(vec[i][j][0]);
          wd.y = sat32(vec[i][j][1]);
          wd.z = sat32(vec[i][j][2]);
          wd.last = (i == du_max) && (j == dv_max);
          pending.push_back(wd);
        end
      end
    endfunction

    // Compare one accepted result word against the oldest prediction.
    function void check_result(surf_word_t got);
      surf_word_t exp_w;
      words_checked++;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result word du=%0d dv=%0d x=%h", $time,
                 got.du, got.dv, got.x);
        errors++;
        return;
      end
      exp_w = pending.pop_front();
      if (got.du !== exp_w.du) begin
        $display("%0t: deriv_across exp %0d got %0d", $time, exp_w.du, got.du);
        errors++;
      end
      if (got.dv !== exp_w.dv) begin
        $display("%0t: deriv_around exp %0d got %0d", $time, exp_w.dv, got.dv);
        errors++;
      end
      if (got.x !== exp_w.x) begin
        $display("%0t: coord_x exp %h got %h", $time, exp_w.x, got.x);
        errors++;
      end
      if (got.y !== exp_w.y) begin
        $display("%0t: coord_y exp %h got %h", $time, exp_w.y, got.y);
        errors++;
      end
      if (got.z !== exp_w.z) begin
        $display("%0t: coord_z exp %h got %h", $time, exp_w.z, got.z);
        errors++;
      end
      if (got.last !== exp_w.last) begin
        $display("%0t: last_result exp %0d got %0d", $time, exp_w.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_stall;
  logic signed [17:0] across = 0;
  logic signed [19:0] around = 0;
  logic [1:0] order_across = 0;
  logic [1:0] order_around = 0;
  logic out_valid;
  logic out_stall = 0;
  logic [1:0] deriv_across, deriv_around;
  logic signed [31:0] coord_x, coord_y, coord_z;
  logic last_result;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [1:0] cfg_index = 0;
  logic [22:0] cfg_data = 0;

  surf_scoreboard sb = new();
  int items_sent = 0;
  int stall_mode = 0;

  // Pipeline latency plus slack; used after results drain before a config write.
  localparam int DRAIN_CYCLES = 80;

  moebius_surface_eval_core i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .across(across), .around(around),
    .order_across(order_across), .order_around(order_around),
    .out_valid(out_valid), .out_stall(out_stall),
    .deriv_across(deriv_across), .deriv_around(deriv_around),
    .coord_x(coord_x), .coord_y(coord_y), .coord_z(coord_z),
    .last_result(last_result),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Receiver: stall pattern changes mode now and then, including no-stall spells.
  always @(posedge clk) begin
    surf_word_t got;
    if (!rst && out_valid && !out_stall) begin
      got.du = deriv_across;
      got.dv = deriv_around;
      got.x = coord_x;
      got.y = coord_y;
      got.z = coord_z;
      got.last = last_result;
      sb.check_result(got);
    end
    if ($urandom_range(0, 63) == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: out_stall <= 0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 1) == 0);
      default: out_stall <= ($urandom_range(0, 7) != 0);
    endcase
  end

  // Present one parameter word and hold it until the block takes it.
  task automatic send_word(logic signed [17:0] u, logic signed [19:0] v,
                           logic [1:0] ou, logic [1:0] ov);
    in_valid <= 1;
    across <= u;
    around <= v;
    order_across <= ou;
    order_around <= ov;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_input(u, v, ou, ov);
    items_sent++;
  endtask

  task automatic go_idle();
    in_valid <= 0;
    @(posedge clk);
  endtask

  // Wait until every predicted word has arrived, then let the pipeline empty.
  task automatic drain();
    in_valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [22:0] data);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.note_config(idx, data);
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  // Mostly in-range parameters; orders include the out-of-range value three.
  task automatic random_burst(int count);
    int n;
    logic signed [17:0] u;
    for (int k = 0; k < count; k++) begin
      n = $urandom_range(0, 5);
      if (n == 0) u = 18'($urandom);
      else u = 18'($signed($urandom_range(0, 131072)) - 65536);
      send_word(u, 20'($urandom), 2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)));
      if ($urandom_range(0, 3) == 0) begin
        go_idle();
        repeat ($urandom_range(0, 12)) @(posedge clk);
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: parameter extremes, every order pair, the order three case.
    send_word(18'sd0, 20'sd0, 2'd0, 2'd0);
    send_word(18'sd65536, 20'sd0, 2'd2, 2'd2);
    send_word(-18'sd65536, 20'sd0, 2'd2, 2'd2);
    send_word(18'sd65536, 20'sd524287, 2'd1, 2'd2);
    send_word(-18'sd65536, -20'sd524288, 2'd2, 2'd1);
    send_word(18'sd131071, 20'sd205887, 2'd3, 2'd3);
    send_word(-18'sd131072, -20'sd205887, 2'd3, 2'd0);
    send_word(18'sd32768, 20'sd102944, 2'd0, 2'd3);
    send_word(18'sd32768, 20'sd102943, 2'd1, 2'd1);
    send_word(18'sd1, 20'sd411774, 2'd0, 2'd1);
    send_word(-18'sd1, -20'sd411774, 2'd1, 2'd0);
    go_idle();
    // Hold off until everything arrives at least once.
    drain();

    // Derivatives off, and the largest radius and width that cfg_data can carry.
    write_reg(mse_pkg::REG_DERIV_EN, 23'd0);
    write_reg(mse_pkg::REG_RADIUS, 23'h7FFFFF);
    write_reg(mse_pkg::REG_HALF_WIDTH, 23'h7FFFFF);
    send_word(18'sd65536, 20'sd0, 2'd2, 2'd2);
    send_word(-18'sd65536, 20'sd205887, 2'd3, 2'd1);
    random_burst(20);
    drain();

    write_reg(mse_pkg::REG_DERIV_EN, 23'd1);
    random_burst(40);
    drain();

    // Zero radius and width, and a write to the unused index.
    write_reg(mse_pkg::REG_RADIUS, 23'd0);
    write_reg(mse_pkg::REG_HALF_WIDTH, 23'd0);
    write_reg(2'd3, 23'h5A5A5A);
    send_word(18'sd65536, 20'sd100000, 2'd2, 2'd2);
    random_burst(20);
    drain();

    write_reg(mse_pkg::REG_RADIUS, 23'($urandom));
    write_reg(mse_pkg::REG_HALF_WIDTH, 23'($urandom));
    random_burst(50);
    drain();

    write_reg(mse_pkg::REG_RADIUS, 23'd65536);
    write_reg(mse_pkg::REG_HALF_WIDTH, 23'd32768);
    random_burst(50);
    drain();

    $display("Sent %0d parameter words over six register settings; checked %0d result words.",
             items_sent, sb.words_checked);
    if (sb.errors == 0) begin
      $display("moebius_surface_eval_core_tb: PASS");
    end else begin
      $display("moebius_surface_eval_core_tb: FAIL");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Timeout with %0d result words outstanding.", sb.pending.size());
    $display("moebius_surface_eval_core_tb: FAIL");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/mse_pkg.sv
rtl/mse_trig.sv
rtl/moebius_surface_eval_core.sv
bench/moebius_surface_eval_core_tb.sv
